[hw/rtl/bfpa_pkg.sv]
// Package for the best-fit pool allocator: sizes, widths, status codes and
// sequencer states. Used by best_fit_pool_allocator.
package bfpa_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int MIN_BLOCK    = 8;
    localparam int MAX_ALLOCS   = 32;
    localparam int FREE_DEPTH   = MAX_ALLOCS + 1;
    localparam int POOL_FLOOR   = 8;
    localparam int POOL_RESET   = 16384;

    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int FIDX_W = $clog2(FREE_DEPTH);
    localparam int SLOT_W = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
    localparam int ENT_W  = 32;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_BADADDR = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_AF_RD,
        S_AF_CK,
        S_FU_RD,
        S_FU_CK,
        S_FN_RD,
        S_FN_CK,
        S_DR_RD,
        S_DR_WR,
        S_PS_RD,
        S_PS_CK,
        S_SH_RD,
        S_SH_WR,
        S_PW,
        S_FIN
    } t_state;

endpackage

[hw/rtl/bfpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/best_fit_pool_allocator.sv]
// Top level of the best-fit pool allocator: request sequencer, free and
// reserved extent tables. Depends on bfpa_pkg and bfpa_ram.
//
// One request is in work at a time, and every table entry it visits goes
// through the single read and write port of each table RAM:
// an allocate walks the size-sorted free table to the fit, shifts the tail
// down to drop it and walks and shifts again to insert the leftover; a free
// walks the reserved table, then the free table for neighbors, then drops
// and inserts. After reset and after each pool_size write the block
// rebuilds the free table in S_INIT before it takes a request. A finished
// result sits in an output register so the next request can be taken while
// it waits.
module best_fit_pool_allocator import bfpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_user_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_address,
    output logic [15:0] o_granted_size
);

    localparam logic [16:0] HDR17   = 17'(HEADER_BYTES);
    localparam logic [16:0] MIN17   = 17'(MIN_BLOCK);
    localparam logic [15:0] HDR16   = 16'(HEADER_BYTES);
    localparam logic [15:0] MIN16   = 16'(MIN_BLOCK);
    localparam logic [CNT_W-1:0] FDEPTH_C = CNT_W'(FREE_DEPTH);
    localparam logic [CNT_W-1:0] MAXA_C   = CNT_W'(MAX_ALLOCS);

    t_state r_state, n_state;
    t_status r_status, n_status;
    logic [15:0] r_pool, n_pool;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAX_ALLOCS-1:0] r_used_valid, n_used_valid;
    logic r_mode, n_mode;
    logic [16:0] r_need, n_need;
    logic [15:0] r_off, n_off;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_drop_b, n_drop_b;
    logic r_drop_b_v, n_drop_b_v;
    logic r_put_v, n_put_v;
    logic [15:0] r_put_off, n_put_off;
    logic [15:0] r_put_sz, n_put_sz;
    logic r_pred_v, n_pred_v;
    logic r_succ_v, n_succ_v;
    logic [CNT_W-1:0] r_pred_ix, n_pred_ix;
    logic [CNT_W-1:0] r_succ_ix, n_succ_ix;
    logic [15:0] r_pred_off, n_pred_off;
    logic [15:0] r_succ_sz, n_succ_sz;
    logic [15:0] r_start, n_start;
    logic [16:0] r_end, n_end;
    logic r_out_v, n_out_v;
    t_status r_o_status, n_o_status;
    logic [15:0] r_o_addr, n_o_addr;
    logic [15:0] r_o_size, n_o_size;

    // Free table RAM ports.
    logic f_we;
    logic [FIDX_W-1:0] f_waddr, f_raddr;
    logic [ENT_W-1:0] f_wdata, f_rdata;
    // Reserved table RAM ports.
    logic u_we;
    logic [SLOT_W-1:0] u_waddr, u_raddr;
    logic [ENT_W-1:0] u_wdata, u_rdata;

    logic w_slot_ok;
    logic [SLOT_W-1:0] w_slot;
    logic [15:0] w_fo, w_fsz;
    logic [16:0] w_fe;
    logic [15:0] w_rem;
    logic [15:0] w_new_start;
    logic [15:0] w_new_end;

    bfpa_ram #(.WIDTH(ENT_W), .DEPTH(FREE_DEPTH)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(f_waddr),
        .i_wdata(f_wdata),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    bfpa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ALLOCS)) u_used_ram (
        .i_clk  (i_clk),
        .i_we   (u_we),
        .i_waddr(u_waddr),
        .i_wdata(u_wdata),
        .i_raddr(u_raddr),
        .o_rdata(u_rdata)
    );

    // Lowest reservation slot that is not in use.
    always_comb begin
        w_slot_ok = 1'b0;
        w_slot    = '0;
        for (int k = MAX_ALLOCS - 1; k >= 0; k--) begin
            if (!r_used_valid[k]) begin
                w_slot_ok = 1'b1;
                w_slot    = SLOT_W'(k);
            end
        end
    end

    assign w_fo  = f_rdata[31:16];
    assign w_fsz = f_rdata[15:0];
    assign w_fe  = {1'b0, w_fo} + {1'b0, w_fsz};
    assign w_rem = w_fsz - r_need[15:0];
    assign w_new_start = r_pred_v ? r_pred_off : r_start;
    assign w_new_end   = r_succ_v ? (r_end[15:0] + r_succ_sz) : r_end[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_pool       <= 16'(POOL_RESET);
            r_cnt        <= '0;
            r_used_valid <= '0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pool       <= n_pool;
            r_cnt        <= n_cnt;
            r_used_valid <= n_used_valid;
            r_out_v      <= n_out_v;
        end
        r_status   <= n_status;
        r_mode     <= n_mode;
        r_need     <= n_need;
        r_off      <= n_off;
        r_slot     <= n_slot;
        r_j        <= n_j;
        r_pos      <= n_pos;
        r_drop_b   <= n_drop_b;
        r_drop_b_v <= n_drop_b_v;
        r_put_v    <= n_put_v;
        r_put_off  <= n_put_off;
        r_put_sz   <= n_put_sz;
        r_pred_v   <= n_pred_v;
        r_succ_v   <= n_succ_v;
        r_pred_ix  <= n_pred_ix;
        r_succ_ix  <= n_succ_ix;
        r_pred_off <= n_pred_off;
        r_succ_sz  <= n_succ_sz;
        r_start    <= n_start;
        r_end      <= n_end;
        r_o_status <= n_o_status;
        r_o_addr   <= n_o_addr;
        r_o_size   <= n_o_size;
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_pool       = r_pool;
        n_cnt        = r_cnt;
        n_used_valid = r_used_valid;
        n_mode       = r_mode;
        n_need       = r_need;
        n_off        = r_off;
        n_slot       = r_slot;
        n_j          = r_j;
        n_pos        = r_pos;
        n_drop_b     = r_drop_b;
        n_drop_b_v   = r_drop_b_v;
        n_put_v      = r_put_v;
        n_put_off    = r_put_off;
        n_put_sz     = r_put_sz;
        n_pred_v     = r_pred_v;
        n_succ_v     = r_succ_v;
        n_pred_ix    = r_pred_ix;
        n_succ_ix    = r_succ_ix;
        n_pred_off   = r_pred_off;
        n_succ_sz    = r_succ_sz;
        n_start      = r_start;
        n_end        = r_end;
        n_out_v      = r_out_v;
        n_o_status   = r_o_status;
        n_o_addr     = r_o_addr;
        n_o_size     = r_o_size;
        f_we    = 1'b0;
        f_waddr = r_j[FIDX_W-1:0];
        f_wdata = f_rdata;
        f_raddr = r_j[FIDX_W-1:0];
        u_we    = 1'b0;
        u_waddr = r_slot;
        u_wdata = {r_off, r_need[15:0]};
        u_raddr = r_j[SLOT_W-1:0];
        o_stall = (r_state != S_IDLE);

        if (r_out_v && !i_stall) begin
            n_out_v = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                f_we         = 1'b1;
                f_waddr      = '0;
                f_wdata      = {16'd0, r_pool};
                n_cnt        = CNT_W'(1);
                n_used_valid = '0;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_pool  = (i_cfg_data < 16'(POOL_FLOOR)) ? 16'(POOL_FLOOR) : i_cfg_data;
                    n_state = S_INIT;
                end else if (i_valid) begin
                    n_mode     = i_mode;
                    n_j        = '0;
                    n_drop_b_v = 1'b0;
                    n_put_v    = 1'b0;
                    n_pred_v   = 1'b0;
                    n_succ_v   = 1'b0;
                    if (!i_mode) begin
                        n_need  = ({1'b0, i_req_size} + HDR17 < MIN17) ?
                                  MIN17 : {1'b0, i_req_size} + HDR17;
                        n_state = S_AF_RD;
                    end else if (i_user_address < HDR16) begin
                        n_status = STAT_BADADDR;
                        n_state  = S_FIN;
                    end else begin
                        n_off   = i_user_address - HDR16;
                        n_state = S_FU_RD;
                    end
                end
            end
            S_AF_RD: begin
                if (r_j < r_cnt) begin
                    n_state = S_AF_CK;
                end else begin
                    n_status = STAT_NOFIT;
                    n_state  = S_FIN;
                end
            end
            S_AF_CK: begin
                if ({1'b0, w_fsz} >= r_need) begin
                    if (!w_slot_ok) begin
                        n_status = STAT_FULL;
                        n_state  = S_FIN;
                    end else begin
                        n_status = STAT_OK;
                        n_off    = w_fo;
                        n_slot   = w_slot;
                        // A leftover below the minimum block goes out with the grant.
                        if (w_rem < MIN16) begin
                            n_need  = {1'b0, w_fsz};
                            n_put_v = 1'b0;
                        end else begin
                            n_put_v   = 1'b1;
                            n_put_off = w_fo + r_need[15:0];
                            n_put_sz  = w_rem;
                        end
                        n_state = S_DR_RD;
                    end
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_AF_RD;
                end
            end
            S_FU_RD: begin
                if (r_j < MAXA_C) begin
                    n_state = S_FU_CK;
                end else begin
                    n_status = STAT_BADADDR;
                    n_state  = S_FIN;
                end
            end
            S_FU_CK: begin
                if (r_used_valid[r_j[SLOT_W-1:0]] && u_rdata[31:16] == r_off) begin
                    n_slot  = r_j[SLOT_W-1:0];
                    n_start = r_off;
                    n_end   = {1'b0, r_off} + {1'b0, u_rdata[15:0]};
                    n_j     = '0;
                    n_state = S_FN_RD;
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_FU_RD;
                end
            end
            S_FN_RD: begin
                if (r_j < r_cnt) begin
                    n_state = S_FN_CK;
                end else if (!r_pred_v && !r_succ_v && r_cnt >= FDEPTH_C) begin
                    n_status = STAT_FULL;
                    n_state  = S_FIN;
                end else begin
                    n_status = STAT_OK;
                    n_used_valid[r_slot] = 1'b0;
                    n_put_v   = 1'b1;
                    n_put_off = w_new_start;
                    n_put_sz  = w_new_end - w_new_start;
                    // Two neighbors: drop the higher index first so the lower stays put.
                    if (r_pred_v && r_succ_v) begin
                        n_j        = (r_pred_ix > r_succ_ix) ? r_pred_ix : r_succ_ix;
                        n_drop_b   = (r_pred_ix > r_succ_ix) ? r_succ_ix : r_pred_ix;
                        n_drop_b_v = 1'b1;
                        n_state    = S_DR_RD;
                    end else if (r_pred_v) begin
                        n_j     = r_pred_ix;
                        n_state = S_DR_RD;
                    end else if (r_succ_v) begin
                        n_j     = r_succ_ix;
                        n_state = S_DR_RD;
                    end else begin
                        n_j     = '0;
                        n_state = S_PS_RD;
                    end
                end
            end
            S_FN_CK: begin
                if (w_fe == {1'b0, r_start} && !r_pred_v) begin
                    n_pred_v   = 1'b1;
                    n_pred_ix  = r_j;
                    n_pred_off = w_fo;
                end else if ({1'b0, w_fo} == r_end && !r_succ_v) begin
                    n_succ_v  = 1'b1;
                    n_succ_ix = r_j;
                    n_succ_sz = w_fsz;
                end
                n_j     = r_j + CNT_W'(1);
                n_state = S_FN_RD;
            end
            S_DR_RD: begin
                if ({1'b0, r_j} + (CNT_W+1)'(1) < {1'b0, r_cnt}) begin
                    f_raddr = FIDX_W'(r_j + CNT_W'(1));
                    n_state = S_DR_WR;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_drop_b_v) begin
                        n_drop_b_v = 1'b0;
                        n_j        = r_drop_b;
                        n_state    = S_DR_RD;
                    end else if (r_put_v) begin
                        n_j     = '0;
                        n_state = S_PS_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DR_WR: begin
                f_we    = 1'b1;
                f_waddr = r_j[FIDX_W-1:0];
                n_j     = r_j + CNT_W'(1);
                n_state = S_DR_RD;
            end
            S_PS_RD: begin
                if (r_j < r_cnt) begin
                    n_state = S_PS_CK;
                end else begin
                    n_pos   = r_j;
                    n_j     = r_cnt;
                    n_state = S_SH_RD;
                end
            end
            S_PS_CK: begin
                if (w_fsz < r_put_sz) begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = S_PS_RD;
                end else begin
                    n_pos   = r_j;
                    n_j     = r_cnt;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                if (r_j > r_pos) begin
                    f_raddr = FIDX_W'(r_j - CNT_W'(1));
                    n_state = S_SH_WR;
                end else begin
                    n_state = S_PW;
                end
            end
            S_SH_WR: begin
                f_we    = 1'b1;
                f_waddr = r_j[FIDX_W-1:0];
                n_j     = r_j - CNT_W'(1);
                n_state = S_SH_RD;
            end
            S_PW: begin
                f_we    = 1'b1;
                f_waddr = r_pos[FIDX_W-1:0];
                f_wdata = {r_put_off, r_put_sz};
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_v || !i_stall) begin
                    n_out_v    = 1'b1;
                    n_o_status = r_status;
                    n_o_addr   = '0;
                    n_o_size   = '0;
                    if (!r_mode && r_status == STAT_OK) begin
                        u_we = 1'b1;
                        n_used_valid[r_slot] = 1'b1;
                        n_o_addr = r_off + HDR16;
                        n_o_size = r_need[15:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    assign o_valid           = r_out_v;
    assign o_status          = r_o_status;
    assign o_granted_address = r_o_addr;
    assign o_granted_size    = r_o_size;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FDEPTH_C)
        else $error("free extent count beyond table depth");

    a_init_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |=> r_cnt == CNT_W'(1) && r_used_valid == '0)
        else $error("pool rebuild did not leave one free extent");

    a_grant_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_OK && o_granted_size != 16'd0 |->
        o_granted_size >= MIN16)
        else $error("grant smaller than minimum block");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_cfg_we |=> r_state != S_IDLE)
        else $error("accepted request did not start");

endmodule
